[rtl/rpef_pkg.sv]
// shared types and constants of the row profile edge finder
package rpef_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 20;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SIZE_W     = 13;
  localparam int SPAN_W     = 13;
  localparam int CENTER_W   = 17;
  localparam int SCALE_W    = 24;
  localparam int OFFSET_W   = 15;
  localparam int FRAC_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int BROW_W     = 18;
  localparam int DIST_W     = 30;
  localparam int WIN_W      = 13;
  localparam int RES_W      = STATUS_W + BROW_W + DIST_W + 2 * WIN_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // bit positions of the result fields in tdata
  localparam int BROW_LSB = STATUS_W;
  localparam int DIST_LSB = BROW_LSB + BROW_W;
  localparam int WS_LSB   = DIST_LSB + DIST_W;
  localparam int WE_LSB   = WS_LSB + WIN_W;

  // rounding of the Q.20 product down to Q.8
  localparam int RND_SHIFT = 12;
  localparam int RND_HALF  = 1 << (RND_SHIFT - 1);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // smallest usable image side, window width and row margin
  localparam int MIN_SIZE = 3;
  localparam int ROW_MARGIN = 2;

  // reset values of the configuration registers
  localparam logic [SIZE_W-1:0]          IMAGE_COLS_RST      = 13'd640;
  localparam logic [SIZE_W-1:0]          IMAGE_ROWS_RST      = 13'd480;
  localparam logic signed [SPAN_W-1:0]   SPAN_START_RST      = 13'sd0;
  localparam logic signed [SPAN_W-1:0]   SPAN_END_RST        = 13'sd639;
  localparam logic signed [CENTER_W-1:0] CENTER_Y_RST        = 17'sd0;
  localparam logic [SCALE_W-1:0]         MM_PER_PIXEL_RST    = 24'd65536;
  localparam logic signed [OFFSET_W-1:0] BOUNDARY_OFFSET_RST = 15'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COLS      = 3'd0,
    CFG_IMAGE_ROWS      = 3'd1,
    CFG_SPAN_START      = 3'd2,
    CFG_SPAN_END        = 3'd3,
    CFG_CENTER_Y        = 3'd4,
    CFG_MM_PER_PIXEL    = 3'd5,
    CFG_BOUNDARY_OFFSET = 3'd6
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_TOO_SMALL = 3'd1,
    STATUS_BAD_SCALE = 3'd2,
    STATUS_NARROW    = 3'd3,
    STATUS_FEW_ROWS  = 3'd4
  } status_e;

endpackage

[rtl/row_profile_edge_finder_top.sv]
// row profile edge finder: row sums, strongest row-to-row step and distance result
// throughput: one pixel item per cycle unless the sink stalls the full result pipeline;
//   a frame's result passes boundary row, status/abs stage, multiplier and rounding
// frames of a single pixel give one result item per cycle as long as the sink keeps up
// reset (rst_ni low, asynchronous): frame counters and sums cleared, pipeline empty,
//   configuration back to 640 x 480, window 0..639, centre 0, scale 1.0, offset 0
module row_profile_edge_finder_top
  import rpef_pkg::*;
#(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side: pixel items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
  // master side: result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // status, boundary_row, distance_mm,
                                                // window_start, window_end, zero pad
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  // counter and compare widths, all following the size limits
  localparam int CW  = $clog2(MAX_COLS);      // column counter
  localparam int CEW = $clog2(MAX_COLS + 1);  // effective column count
  localparam int RW  = $clog2(MAX_ROWS);      // row counter
  localparam int REW = $clog2(MAX_ROWS + 1);  // effective row count
  localparam int CMW = (CEW > SIZE_W) ? CEW : SIZE_W;
  localparam int RMW = (REW > SIZE_W) ? REW : SIZE_W;
  localparam int XW  = ((CEW > SPAN_W) ? CEW : SPAN_W) + 2;  // signed column maths
  localparam int YW  = ((REW > SPAN_W) ? REW : SPAN_W) + 2;  // signed row maths
  localparam int BW  = ((RW + FRAC_W + 1 > OFFSET_W) ? RW + FRAC_W + 1 : OFFSET_W) + 1;
  localparam int DW  = ((BW > CENTER_W) ? BW : CENTER_W) + 1;
  localparam int PW  = DW + SCALE_W;
  localparam int QW  = PW + 1 - RND_SHIFT;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]          image_cols_q, image_rows_q;
  logic signed [SPAN_W-1:0]   span_start_q, span_end_q;
  logic signed [CENTER_W-1:0] center_y_q;
  logic [SCALE_W-1:0]         mm_per_pixel_q;
  logic signed [OFFSET_W-1:0] boundary_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_cols_q      <= IMAGE_COLS_RST;
      image_rows_q      <= IMAGE_ROWS_RST;
      span_start_q      <= SPAN_START_RST;
      span_end_q        <= SPAN_END_RST;
      center_y_q        <= CENTER_Y_RST;
      mm_per_pixel_q    <= MM_PER_PIXEL_RST;
      boundary_offset_q <= BOUNDARY_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_COLS:      image_cols_q      <= cfg_data_i[SIZE_W-1:0];
        CFG_IMAGE_ROWS:      image_rows_q      <= cfg_data_i[SIZE_W-1:0];
        CFG_SPAN_START:      span_start_q      <= cfg_data_i[SPAN_W-1:0];
        CFG_SPAN_END:        span_end_q        <= cfg_data_i[SPAN_W-1:0];
        CFG_CENTER_Y:        center_y_q        <= cfg_data_i[CENTER_W-1:0];
        CFG_MM_PER_PIXEL:    mm_per_pixel_q    <= cfg_data_i[SCALE_W-1:0];
        CFG_BOUNDARY_OFFSET: boundary_offset_q <= cfg_data_i[OFFSET_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // values derived from configuration
  // ---------------------------------------------------------------------------
  logic [CMW-1:0]             cols_x;
  logic [RMW-1:0]             rows_x;
  logic [CEW-1:0]             cols_eff;
  logic [REW-1:0]             rows_eff;
  logic signed [XW-1:0]       x0_s, x1_s, end_p1_s, cols_s, col_s;
  logic signed [CENTER_W-1:0] cbias_s, ytr_s;
  logic signed [YW-1:0]       y_s, hi_s, y_hi_s, y_c_s, rows_s;
  logic [RW-1:0]              y0;

  always_comb begin
    // sizes saturated to [1, max] for framing
    cols_x = CMW'(image_cols_q);
    rows_x = RMW'(image_rows_q);
    if (image_cols_q == '0) begin
      cols_eff = CEW'(1);
    end else if (cols_x > CMW'(MAX_COLS)) begin
      cols_eff = CEW'(MAX_COLS);
    end else begin
      cols_eff = CEW'(cols_x);
    end
    if (image_rows_q == '0) begin
      rows_eff = REW'(1);
    end else if (rows_x > RMW'(MAX_ROWS)) begin
      rows_eff = REW'(MAX_ROWS);
    end else begin
      rows_eff = REW'(rows_x);
    end

    // clipped column window [x0, x1)
    x0_s     = span_start_q[SPAN_W-1] ? '0 : XW'(span_start_q);
    end_p1_s = XW'(span_end_q) + XW'(1);
    cols_s   = XW'(cols_eff);
    x1_s     = (end_p1_s > cols_s) ? cols_s : end_p1_s;

    // start row: centre truncated toward zero, then clamped to [1, rows-2]
    cbias_s = center_y_q + (center_y_q[CENTER_W-1] ? CENTER_W'((1 << FRAC_W) - 1) : '0);
    ytr_s   = cbias_s >>> FRAC_W;
    y_s     = YW'(ytr_s);
    rows_s  = YW'(rows_eff);
    hi_s    = rows_s - YW'(ROW_MARGIN);
    y_hi_s  = (y_s > hi_s) ? hi_s : y_s;
    y_c_s   = (y_hi_s < YW'(1)) ? YW'(1) : y_hi_s;
    y0      = RW'(y_c_s);
  end

  // ---------------------------------------------------------------------------
  // per-pixel accumulation and best step tracking
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q, best_row_q;
  logic [SUM_W-1:0] row_sum_q, prev_sum_q, best_diff_q;
  logic             have_prev_q, best_found_q;

  logic             in_fire, in_rows, in_win, col_last, row_last, frame_end, take_best;
  logic [SUM_W-1:0] sum_acc, step_diff;
  logic [RW-1:0]    final_row;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_s     = XW'(col_q);
    in_rows   = (row_q >= y0);
    in_win    = in_rows && (col_s >= x0_s) && (col_s < x1_s);
    sum_acc   = row_sum_q + (in_win ? SUM_W'(s_axis_tdata) : '0);
    col_last  = (CEW'(col_q) + CEW'(1)) >= cols_eff;
    row_last  = (REW'(row_q) + REW'(1)) >= rows_eff;
    frame_end = in_fire && col_last && row_last;
    step_diff = (sum_acc > prev_sum_q) ? sum_acc - prev_sum_q : prev_sum_q - sum_acc;
    // first strictly larger step wins, so ties keep the earlier row
    take_best = col_last && in_rows && have_prev_q &&
                (!best_found_q || (step_diff > best_diff_q));
    if (take_best) begin
      final_row = row_q - RW'(1);
    end else if (best_found_q) begin
      final_row = best_row_q;
    end else begin
      final_row = y0;  // no pair seen: boundary at the start row
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      row_sum_q    <= '0;
      prev_sum_q   <= '0;
      have_prev_q  <= 1'b0;
      best_found_q <= 1'b0;
      best_diff_q  <= '0;
      best_row_q   <= '0;
    end else if (in_fire) begin
      if (!col_last) begin
        col_q     <= col_q + CW'(1);
        row_sum_q <= sum_acc;
      end else begin
        col_q     <= '0;
        row_sum_q <= '0;
        if (!row_last) begin
          row_q <= row_q + RW'(1);
          if (in_rows) begin
            prev_sum_q  <= sum_acc;
            have_prev_q <= 1'b1;
          end
          if (take_best) begin
            best_diff_q  <= step_diff;
            best_row_q   <= row_q - RW'(1);
            best_found_q <= 1'b1;
          end
        end else begin
          // frame done: all frame state back to zero
          row_q        <= '0;
          prev_sum_q   <= '0;
          have_prev_q  <= 1'b0;
          best_found_q <= 1'b0;
          best_diff_q  <= '0;
          best_row_q   <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result pipeline: s1 boundary row, s2 status and |distance|, s3 product, output
  // the user keeps configuration quiet while a result is in flight, unenforced here; later stages read it live
  // ---------------------------------------------------------------------------
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;

  assign out_free      = !out_v_q || m_axis_tready;
  assign s3_free       = !s3_v_q || out_free;
  assign s2_free       = !s2_v_q || s3_free;
  assign s1_free       = !s1_v_q || s2_free;
  assign s_axis_tready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free)  s1_v_q  <= frame_end;
      if (s2_free)  s2_v_q  <= s1_v_q;
      if (s3_free)  s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
    end
  end

  // stage 1: boundary row of the frame
  logic [RW-1:0] s1_row_q;

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      s1_row_q <= final_row;
    end
  end

  // stage 2: status, boundary in Q.4 and absolute distance to the centre
  status_e              s2_status_d, s2_status_q;
  logic signed [BW-1:0] b_s;
  logic signed [DW-1:0] diff_s;
  logic [DW-1:0]        s2_ad_d, s2_ad_q;
  logic [BROW_W-1:0]    s2_brow_d, s2_brow_q;
  logic [WIN_W-1:0]     s2_ws_d, s2_ws_q, s2_we_d, s2_we_q;

  always_comb begin
    if ((rows_eff < REW'(MIN_SIZE)) || (cols_eff < CEW'(MIN_SIZE))) begin
      s2_status_d = STATUS_TOO_SMALL;
    end else if (mm_per_pixel_q == '0) begin
      s2_status_d = STATUS_BAD_SCALE;
    end else if ((x1_s - x0_s) < XW'(MIN_SIZE)) begin
      s2_status_d = STATUS_NARROW;
    end else if (y_c_s >= hi_s) begin
      s2_status_d = STATUS_FEW_ROWS;
    end else begin
      s2_status_d = STATUS_OK;
    end

    b_s    = BW'($signed({1'b0, s1_row_q, FRAC_W'(0)})) + BW'(boundary_offset_q);
    diff_s = DW'(b_s) - DW'(center_y_q);

    if (s2_status_d == STATUS_OK) begin
      s2_ad_d   = diff_s[DW-1] ? DW'(-diff_s) : DW'(diff_s);
      s2_brow_d = BROW_W'(b_s);
      s2_ws_d   = WIN_W'(x0_s);
      s2_we_d   = WIN_W'(x1_s);
    end else begin
      s2_ad_d   = '0;
      s2_brow_d = '0;
      s2_ws_d   = '0;
      s2_we_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_free) begin
      s2_status_q <= s2_status_d;
      s2_ad_q     <= s2_ad_d;
      s2_brow_q   <= s2_brow_d;
      s2_ws_q     <= s2_ws_d;
      s2_we_q     <= s2_we_d;
    end
  end

  // stage 3: distance times scale, Q.4 x Q8.16 gives Q.20
  status_e           s3_status_q;
  logic [PW-1:0]     s3_prod_d, s3_prod_q;
  logic [BROW_W-1:0] s3_brow_q;
  logic [WIN_W-1:0]  s3_ws_q, s3_we_q;

  assign s3_prod_d = PW'(s2_ad_q) * PW'(mm_per_pixel_q);

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_free) begin
      s3_status_q <= s2_status_q;
      s3_prod_q   <= s3_prod_d;
      s3_brow_q   <= s2_brow_q;
      s3_ws_q     <= s2_ws_q;
      s3_we_q     <= s2_we_q;
    end
  end

  // output stage: round half up to Q.8 and saturate
  status_e           out_status_q;
  logic [PW:0]       rnd;
  logic [QW-1:0]     qv;
  logic [DIST_W-1:0] out_dist_d, out_dist_q;
  logic [BROW_W-1:0] out_brow_q;
  logic [WIN_W-1:0]  out_ws_q, out_we_q;

  always_comb begin
    rnd = (PW + 1)'(s3_prod_q) + (PW + 1)'(RND_HALF);
    qv  = QW'(rnd >> RND_SHIFT);
    out_dist_d = (qv > QW'(DIST_MAX)) ? DIST_MAX : DIST_W'(qv);
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && out_free) begin
      out_status_q <= s3_status_q;
      out_dist_q   <= out_dist_d;
      out_brow_q   <= s3_brow_q;
      out_ws_q     <= s3_ws_q;
      out_we_q     <= s3_we_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), out_we_q, out_ws_q, out_dist_q,
                          out_brow_q, out_status_q};

endmodule

[rtl/rpef_checker.sv]
// port-level checks of the row profile edge finder and their binding
module rpef_checker
  import rpef_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] status;
  logic [WIN_W-1:0]    win_start, win_end;

  assign status    = m_axis_tdata[STATUS_W-1:0];
  assign win_start = m_axis_tdata[WS_LSB +: WIN_W];
  assign win_end   = m_axis_tdata[WE_LSB +: WIN_W];

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // an empty output frees every stage ahead of it, so pixels are taken
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pixel input stalled with empty output");

  // error results carry only the status
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != STATUS_OK) |-> (m_axis_tdata[OUT_DATA_W-1:STATUS_W] == '0))
    else $error("error result with nonzero fields");

  // a good result has a window at least three columns wide
  a_ok_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == STATUS_OK) |-> (win_end >= win_start + WIN_W'(MIN_SIZE)))
    else $error("good result with narrow window");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == STATUS_OK) || (status == STATUS_TOO_SMALL) ||
                      (status == STATUS_BAD_SCALE) || (status == STATUS_NARROW) ||
                      (status == STATUS_FEW_ROWS))
    else $error("unknown status code");

endmodule

bind row_profile_edge_finder_top rpef_checker u_rpef_checker (.*);
